/* rtl/core/hpid_pkg.sv */
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types, widths and codes of the multi-channel heater PID unit.
// ----------------------------------------------------------------------------
package hpid_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GAIN_W     = 20;
  localparam int DUTY_W     = 16;
  localparam int TEMP_W     = 19;
  localparam int TGT_W      = 18;
  localparam int INTEG_W    = 48;
  localparam int FRAC_W     = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int REQ_W      = 2;
  localparam int ALARM_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_ON     = 2'd1,
    REQ_OFF    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [ALARM_W-1:0] {
    ALARM_NONE  = 2'd0,
    ALARM_OVER  = 2'd1,
    ALARM_UNDER = 2'd2
  } alarm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI        = 3'd1,
    CFG_KD        = 3'd2,
    CFG_DUTY_MIN  = 3'd3,
    CFG_DUTY_MAX  = 3'd4,
    CFG_TEMP_HIGH = 3'd5,
    CFG_TEMP_LOW  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic [DUTY_W-1:0]        duty_min;
    logic [DUTY_W-1:0]        duty_max;
    logic signed [TEMP_W-1:0] temp_high;
    logic signed [TEMP_W-1:0] temp_low;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] actual;
    logic signed [TEMP_W-1:0] previous;
    logic [TGT_W-1:0]         target;
    logic [INTEG_W-1:0]       integ;
    logic [DUTY_W-1:0]        duty;
  } chan_state_t;

endpackage

/* rtl/core/multi_channel_heater_pid_unit.sv */
// ----------------------------------------------------------------------------
// multi_channel_heater_pid_unit
// Four-channel PID heater controller with duty clamp and temperature alarms.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while in_stall is low and returns one
// result word per request. A request is latched in an input register; the
// channel's read-modify-write (three 20x20 multiplies, integral update,
// P+I+D sum and clamp) is combinational from that register and is written
// into the result register and channel state together, so requests to the
// same channel may follow each other in consecutive cycles.
module multi_channel_heater_pid_unit
  import hpid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [CH_W-1:0]          in_channel,
  input  logic signed [TEMP_W-1:0] in_temp_sample,
  input  logic [TGT_W-1:0]         in_target_temp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_channel,
  output logic [DUTY_W-1:0]        out_duty,
  output logic [ALARM_W-1:0]       out_alarm,
  output logic                     out_active
);

  cfg_t                     cfg_r;
  logic                     s1_v_r;
  req_t                     s1_req_r;
  logic [CH_W-1:0]          s1_ch_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic [TGT_W-1:0]         s1_tgt_r;
  logic                     out_v_r;
  logic [CH_W-1:0]          out_ch_r;
  logic [DUTY_W-1:0]        out_duty_r;
  alarm_t                   out_alarm_r;
  logic                     out_active_r;

  logic                     adv;
  logic                     in_acc;
  logic                     ch_ok;
  logic [CH_IDX_W-1:0]      ch_idx;
  chan_state_t              cur;
  chan_state_t              nxt;
  alarm_t                   alarm;
  logic [DUTY_W-1:0]        res_duty_nxt;
  alarm_t                   res_alarm_nxt;
  logic                     res_active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= GAIN_W'(81920);
      cfg_r.ki        <= GAIN_W'(410);
      cfg_r.kd        <= '0;
      cfg_r.duty_min  <= '0;
      cfg_r.duty_max  <= DUTY_W'(1000);
      cfg_r.temp_high <= TEMP_W'(38400);
      cfg_r.temp_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:        cfg_r.kp        <= cfg_wdata[GAIN_W-1:0];
        CFG_KI:        cfg_r.ki        <= cfg_wdata[GAIN_W-1:0];
        CFG_KD:        cfg_r.kd        <= cfg_wdata[GAIN_W-1:0];
        CFG_DUTY_MIN:  cfg_r.duty_min  <= cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_MAX:  cfg_r.duty_max  <= cfg_wdata[DUTY_W-1:0];
        CFG_TEMP_HIGH: cfg_r.temp_high <= $signed(cfg_wdata[TEMP_W-1:0]);
        CFG_TEMP_LOW:  cfg_r.temp_low  <= $signed(cfg_wdata[TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= req_t'(in_req_type);
      s1_ch_r   <= in_channel;
      s1_temp_r <= in_temp_sample;
      s1_tgt_r  <= in_target_temp;
    end
  end

  assign ch_ok  = (32'(s1_ch_r) < CHANNELS);
  assign ch_idx = CH_IDX_W'(s1_ch_r);

  hpid_chan_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (ch_idx),
    .rd_state (cur),
    .wr_en    (adv && s1_v_r && ch_ok),
    .wr_idx   (ch_idx),
    .wr_state (nxt)
  );

  hpid_calc u_calc (
    .cfg    (cfg_r),
    .req    (s1_req_r),
    .sample (s1_temp_r),
    .target (s1_tgt_r),
    .cur    (cur),
    .nxt    (nxt),
    .alarm  (alarm)
  );

  always_comb begin
    if (ch_ok) begin
      res_duty_nxt   = nxt.duty;
      res_alarm_nxt  = alarm;
      res_active_nxt = (nxt.target != '0);
    end else begin
      res_duty_nxt   = '0;
      res_alarm_nxt  = ALARM_NONE;
      res_active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_ch_r     <= s1_ch_r;
      out_duty_r   <= res_duty_nxt;
      out_alarm_r  <= res_alarm_nxt;
      out_active_r <= res_active_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_channel = out_ch_r;
  assign out_duty    = out_duty_r;
  assign out_alarm   = out_alarm_r;
  assign out_active  = out_active_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_v_r) |=> out_v_r)
    else $error("pending request did not reach the result register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && s1_v_r && !adv) |-> in_stall)
    else $error("input register overrun");

  a_alarm_sample_only: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_v_r && s1_req_r != REQ_SAMPLE) |=> (out_alarm == ALARM_NONE))
    else $error("alarm raised on a non-sample request");

  a_off_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_v_r && s1_req_r == REQ_OFF) |=> !out_active)
    else $error("heater off reported active");

endmodule

/* rtl/core/hpid_chan_regs.sv */
// ----------------------------------------------------------------------------
// hpid_chan_regs
// Per-channel controller state: temperatures, target, integral, duty.
// ----------------------------------------------------------------------------
module hpid_chan_regs
  import hpid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CH_IDX_W-1:0] rd_idx,
  output chan_state_t         rd_state,
  input  logic                wr_en,
  input  logic [CH_IDX_W-1:0] wr_idx,
  input  chan_state_t         wr_state
);

  chan_state_t state_r [CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_r[i] <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_idx] <= wr_state;
    end
  end

  assign rd_state = state_r[rd_idx];

endmodule

/* rtl/core/hpid_calc.sv */
// ----------------------------------------------------------------------------
// hpid_calc
// One request against one channel: state update, PID sum, duty clamp, alarm.
// ----------------------------------------------------------------------------
module hpid_calc
  import hpid_pkg::*;
(
  input  cfg_t                     cfg,
  input  req_t                     req,
  input  logic signed [TEMP_W-1:0] sample,
  input  logic [TGT_W-1:0]         target,
  input  chan_state_t              cur,
  output chan_state_t              nxt,
  output alarm_t                   alarm
);

  localparam int PROD_W = GAIN_W + TEMP_W + 3;
  localparam int ISUM_W = INTEG_W + 2;
  localparam int SUM_W  = INTEG_W + 3;

  logic signed [TEMP_W-1:0] act_e;
  logic signed [TEMP_W-1:0] prev_e;
  logic [TGT_W-1:0]         tgt_e;
  logic [INTEG_W-1:0]       integ_b;
  logic                     do_pid;

  logic signed [TEMP_W:0]   err;
  logic signed [TEMP_W:0]   dif;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0] d_prod;
  logic signed [ISUM_W-1:0] integ_sum;
  logic [INTEG_W-1:0]       integ_cl;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  min_lim;
  logic signed [SUM_W-1:0]  max_lim;
  logic [DUTY_W-1:0]        duty_pid;

  always_comb begin
    act_e   = cur.actual;
    prev_e  = cur.previous;
    tgt_e   = cur.target;
    integ_b = cur.integ;
    do_pid  = 1'b0;
    alarm   = ALARM_NONE;
    unique case (req)
      REQ_SAMPLE: begin
        prev_e = cur.actual;
        act_e  = sample;
        do_pid = (cur.target != '0);
        if (sample > cfg.temp_high) begin
          alarm = ALARM_OVER;
        end else if (sample < cfg.temp_low) begin
          alarm = ALARM_UNDER;
        end
      end
      REQ_ON: begin
        tgt_e  = target;
        do_pid = 1'b1;
        if (!(target > cur.target)) begin
          integ_b = '0;
        end
      end
      REQ_OFF: begin
        tgt_e = '0;
      end
      default: begin
      end
    endcase
  end

  assign err = $signed({2'b00, tgt_e}) - $signed({act_e[TEMP_W-1], act_e});
  assign dif = $signed({prev_e[TEMP_W-1], prev_e}) - $signed({act_e[TEMP_W-1], act_e});

  assign p_prod = PROD_W'($signed({1'b0, cfg.kp}) * err);
  assign i_prod = PROD_W'($signed({1'b0, cfg.ki}) * err);
  assign d_prod = PROD_W'($signed({1'b0, cfg.kd}) * dif);

  assign integ_sum = $signed({2'b00, integ_b})
                   + $signed({{(ISUM_W-PROD_W){i_prod[PROD_W-1]}}, i_prod});

  always_comb begin
    if (integ_sum < 0) begin
      integ_cl = '0;
    end else if (integ_sum[ISUM_W-1:INTEG_W] != '0) begin
      integ_cl = '1;
    end else begin
      integ_cl = integ_sum[INTEG_W-1:0];
    end
  end

  assign sum = $signed({3'b000, integ_cl})
             + $signed({{(SUM_W-PROD_W){p_prod[PROD_W-1]}}, p_prod})
             + $signed({{(SUM_W-PROD_W){d_prod[PROD_W-1]}}, d_prod});

  assign min_lim = $signed({{(SUM_W-DUTY_W-FRAC_W){1'b0}}, cfg.duty_min, {FRAC_W{1'b0}}});
  assign max_lim = $signed({{(SUM_W-DUTY_W-FRAC_W){1'b0}}, cfg.duty_max, {FRAC_W{1'b0}}});

  always_comb begin
    priority if (sum <= min_lim) begin
      duty_pid = cfg.duty_min;
    end else if (sum >= max_lim) begin
      duty_pid = cfg.duty_max;
    end else begin
      duty_pid = sum[FRAC_W+DUTY_W-1:FRAC_W];
    end
  end

  always_comb begin
    nxt          = cur;
    nxt.actual   = act_e;
    nxt.previous = prev_e;
    nxt.target   = tgt_e;
    if (do_pid) begin
      nxt.integ = integ_cl;
      nxt.duty  = duty_pid;
    end else if (req == REQ_OFF) begin
      nxt.duty = cfg.duty_min;
    end
  end

endmodule
